[src/rdpc_pkg.sv]
// Package for the radix digit pack codec: field widths, register indexes,
// item and configuration types, the reciprocal table and small helper functions.
// Depends on nothing; every other file of the block imports it.
package rdpc_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int MAX_LEVELS   = 8;
    localparam int RADIX_W      = 5;
    localparam int LEVELS_W     = 4;
    localparam int DIGIT_W      = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int LEVEL_W      = $clog2(MAX_LEVELS + 1);
    localparam int SHIFT_W      = $clog2((MAX_LEVELS - 1) * DIGIT_W + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [RADIX_W-1:0]  RADIX_RESET  = RADIX_W'(2);
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = LEVELS_W'(2);
    localparam logic [RADIX_W-1:0]  RADIX_MIN    = RADIX_W'(2);

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVELS = CFG_INDEX_W'(1);

    typedef enum logic {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  en;
        logic [DATA_WIDTH-1:0] value;
    } item_t;

    typedef struct packed {
        logic [RADIX_W-1:0]    radix;
        logic [DATA_WIDTH-1:0] recip;
        logic [2:0]            width;
        logic [DIGIT_W-1:0]    field_mask;
        logic [LEVEL_W-1:0]    levels_used;
    } cfg_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  en;
        logic [DATA_WIDTH-1:0] val;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] weight;
    } pipe_t;

    localparam logic [2*DATA_WIDTH-1:0] RECIP_NUM = (2*DATA_WIDTH)'(1) << DATA_WIDTH;

    // Entry d, for d of two or more, holds floor(2^DATA_WIDTH / d); the first two entries hold zero.
    localparam logic [DATA_WIDTH-1:0] RECIP_TABLE [2**RADIX_W] = '{
        DATA_WIDTH'(0),             DATA_WIDTH'(0),
        DATA_WIDTH'(RECIP_NUM / 2), DATA_WIDTH'(RECIP_NUM / 3),
        DATA_WIDTH'(RECIP_NUM / 4), DATA_WIDTH'(RECIP_NUM / 5),
        DATA_WIDTH'(RECIP_NUM / 6), DATA_WIDTH'(RECIP_NUM / 7),
        DATA_WIDTH'(RECIP_NUM / 8), DATA_WIDTH'(RECIP_NUM / 9),
        DATA_WIDTH'(RECIP_NUM / 10), DATA_WIDTH'(RECIP_NUM / 11),
        DATA_WIDTH'(RECIP_NUM / 12), DATA_WIDTH'(RECIP_NUM / 13),
        DATA_WIDTH'(RECIP_NUM / 14), DATA_WIDTH'(RECIP_NUM / 15),
        DATA_WIDTH'(RECIP_NUM / 16), DATA_WIDTH'(RECIP_NUM / 17),
        DATA_WIDTH'(RECIP_NUM / 18), DATA_WIDTH'(RECIP_NUM / 19),
        DATA_WIDTH'(RECIP_NUM / 20), DATA_WIDTH'(RECIP_NUM / 21),
        DATA_WIDTH'(RECIP_NUM / 22), DATA_WIDTH'(RECIP_NUM / 23),
        DATA_WIDTH'(RECIP_NUM / 24), DATA_WIDTH'(RECIP_NUM / 25),
        DATA_WIDTH'(RECIP_NUM / 26), DATA_WIDTH'(RECIP_NUM / 27),
        DATA_WIDTH'(RECIP_NUM / 28), DATA_WIDTH'(RECIP_NUM / 29),
        DATA_WIDTH'(RECIP_NUM / 30), DATA_WIDTH'(RECIP_NUM / 31)
    };

    function automatic logic [2:0] digit_width(input logic [RADIX_W-1:0] k);
        logic [2:0] w;
        if (k <= RADIX_W'(1)) begin
            w = 3'd0;
        end else if (k <= RADIX_W'(2)) begin
            w = 3'd1;
        end else if (k <= RADIX_W'(4)) begin
            w = 3'd2;
        end else if (k <= RADIX_W'(8)) begin
            w = 3'd3;
        end else if (k <= RADIX_W'(16)) begin
            w = 3'd4;
        end else begin
            w = 3'd5;
        end
        return w;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_mask(input logic [2:0] w);
        return DIGIT_W'((1 << w) - 1);
    endfunction

endpackage

[src/radix_digit_pack_codec_top.sv]
// Top level of the radix digit pack codec: front, queue and digit pipeline.
// Depends on rdpc_pkg, rdpc_front, rdpc_queue and rdpc_back.
//
//  Channel   Ports                                     Transfer
//  command   start, busy, kind, value                  start && !busy
//  result    done, result                              done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One command is taken per cycle while busy is low; its result is taken after it has
// passed the front register, the queue slot and the
// three stages of each digit unit.
// Reset clears the valid flags and the queue and loads radix 2 and two levels.
// The result side cannot stall, so busy only rises if the queue were ever full.
module radix_digit_pack_codec_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [rdpc_pkg::DATA_WIDTH-1:0]  value,
    output logic                             done,
    output logic [rdpc_pkg::DATA_WIDTH-1:0]  result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rdpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rdpc_pkg::*;

    logic  push;
    item_t push_item;
    logic  full;
    logic  empty;
    item_t pop_item;
    cfg_t  cfg;

    rdpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .cfg       (cfg)
    );

    rdpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (!empty),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    rdpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!empty),
        .in_item  (pop_item),
        .cfg      (cfg),
        .done     (done),
        .result   (result)
    );

endmodule

[src/rdpc_front.sv]
// Front part of the codec: holds the configuration registers, accepts commands
// and classifies each item before it is pushed into the queue.
// Depends on rdpc_pkg.
module rdpc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [rdpc_pkg::DATA_WIDTH-1:0]  value,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rdpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             push,
    output rdpc_pkg::item_t                  push_item,
    input  logic                             full,
    output rdpc_pkg::cfg_t                   cfg
);
    import rdpc_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic [LEVELS_W-1:0]   levels_reg;
    logic [DATA_WIDTH-1:0] recip_reg;
    logic [2:0]            width_reg;
    logic [DIGIT_W-1:0]    mask_reg;
    logic                  item_valid_reg;
    logic                  item_valid_next;
    item_t                 item_reg;
    logic                  accept;
    logic                  cfg_write;
    logic [RADIX_W-1:0]    new_radix;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign new_radix = cfg_data[RADIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= RADIX_RESET;
            levels_reg <= LEVELS_RESET;
            recip_reg  <= RECIP_TABLE[RADIX_RESET];
            width_reg  <= digit_width(RADIX_RESET);
            mask_reg   <= digit_mask(digit_width(RADIX_RESET));
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RADIX:
                begin
                    radix_reg <= new_radix;
                    recip_reg <= RECIP_TABLE[new_radix];
                    width_reg <= digit_width(new_radix);
                    mask_reg  <= digit_mask(digit_width(new_radix));
                end
                CFG_LEVELS:
                begin
                    levels_reg <= cfg_data[LEVELS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.radix      = radix_reg;
        cfg.recip      = recip_reg;
        cfg.width      = width_reg;
        cfg.field_mask = mask_reg;
        if (levels_reg > LEVELS_W'(MAX_LEVELS))
        begin
            cfg.levels_used = LEVEL_W'(MAX_LEVELS);
        end
        else
        begin
            cfg.levels_used = LEVEL_W'(levels_reg);
        end
    end

    assign busy   = item_valid_reg && full;
    assign accept = start && !busy;
    assign push   = item_valid_reg && !full;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (push)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind  <= kind_t'(kind);
            item_reg.en    <= (radix_reg >= RADIX_MIN) && (levels_reg != '0);
            item_reg.value <= value;
        end
    end

    assign push_item = item_reg;

endmodule

[src/rdpc_queue.sv]
// Short queue that parts the front of the codec from its digit pipeline.
// Depends on rdpc_pkg for the item type and the queue depth.
module rdpc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rdpc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output rdpc_pkg::item_t pop_item,
    output logic            empty
);
    import rdpc_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = entry_reg[rd_ptr_reg];

endmodule

[src/rdpc_back.sv]
// Back part of the codec: one three-stage unit per tree level that extracts or
// accumulates one digit, using a reciprocal multiply with a single correction.
// Depends on rdpc_pkg.
module rdpc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  rdpc_pkg::item_t                 in_item,
    input  rdpc_pkg::cfg_t                  cfg,
    output logic                            done,
    output logic [rdpc_pkg::DATA_WIDTH-1:0] result
);
    import rdpc_pkg::*;

    pipe_t stage_data  [MAX_LEVELS+1];
    logic  stage_valid [MAX_LEVELS+1];

    assign stage_valid[0] = in_valid;
    assign stage_data[0]  = {in_item.kind, in_item.en, in_item.value,
                             DATA_WIDTH'(0), DATA_WIDTH'(1)};

    genvar i;
    generate
        for (i = 0; i < MAX_LEVELS; i++)
        begin : g_digit
            logic                    a_valid_reg;
            logic                    b_valid_reg;
            logic                    c_valid_reg;
            pipe_t                   a_reg;
            pipe_t                   b_reg;
            pipe_t                   c_reg;
            pipe_t                   c_next;
            logic [2*DATA_WIDTH-1:0] a_prod_reg;
            logic [DATA_WIDTH-1:0]   a_term_reg;
            logic [DATA_WIDTH-1:0]   a_wnext_reg;
            logic [DATA_WIDTH-1:0]   b_q_reg;
            logic [DATA_WIDTH-1:0]   b_qd_reg;
            logic [DATA_WIDTH-1:0]   b_sum_reg;
            logic [DATA_WIDTH-1:0]   b_wnext_reg;
            logic [SHIFT_W-1:0]      sh;
            logic                    active;
            logic [DIGIT_W-1:0]      field;
            logic [DATA_WIDTH-1:0]   rem_raw;
            logic [DATA_WIDTH-1:0]   rem;
            logic [DATA_WIDTH-1:0]   quo;

            assign sh     = SHIFT_W'(i) * SHIFT_W'(cfg.width);
            assign active = (LEVEL_W'(i) < cfg.levels_used);
            assign field  = DIGIT_W'(stage_data[i].val >> sh) & cfg.field_mask;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    a_valid_reg <= 1'b0;
                    b_valid_reg <= 1'b0;
                    c_valid_reg <= 1'b0;
                end
                else
                begin
                    a_valid_reg <= stage_valid[i];
                    b_valid_reg <= a_valid_reg;
                    c_valid_reg <= b_valid_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                a_reg       <= stage_data[i];
                a_prod_reg  <= (2*DATA_WIDTH)'(stage_data[i].val)
                               * (2*DATA_WIDTH)'(cfg.recip);
                a_term_reg  <= DATA_WIDTH'(DATA_WIDTH'(field) * stage_data[i].weight);
                a_wnext_reg <= DATA_WIDTH'(stage_data[i].weight * DATA_WIDTH'(cfg.radix));
                b_reg       <= a_reg;
                b_q_reg     <= a_prod_reg[2*DATA_WIDTH-1:DATA_WIDTH];
                b_qd_reg    <= DATA_WIDTH'(a_prod_reg[2*DATA_WIDTH-1:DATA_WIDTH]
                                           * DATA_WIDTH'(cfg.radix));
                b_sum_reg   <= a_reg.acc + a_term_reg;
                b_wnext_reg <= a_wnext_reg;
                c_reg       <= c_next;
            end

            always_comb
            begin
                rem_raw = b_reg.val - b_qd_reg;
                if (rem_raw >= DATA_WIDTH'(cfg.radix))
                begin
                    quo = b_q_reg + DATA_WIDTH'(1);
                    rem = rem_raw - DATA_WIDTH'(cfg.radix);
                end
                else
                begin
                    quo = b_q_reg;
                    rem = rem_raw;
                end
                c_next = b_reg;
                if (active)
                begin
                    if (b_reg.kind == KIND_DECODE)
                    begin
                        c_next.acc    = b_sum_reg;
                        c_next.weight = b_wnext_reg;
                    end
                    else
                    begin
                        c_next.val = quo;
                        c_next.acc = b_reg.acc | (DATA_WIDTH'(rem[DIGIT_W-1:0]) << sh);
                    end
                end
            end

            assign stage_data[i+1]  = c_reg;
            assign stage_valid[i+1] = c_valid_reg;
        end
    endgenerate

    assign done   = stage_valid[MAX_LEVELS];
    assign result = stage_data[MAX_LEVELS].en ? stage_data[MAX_LEVELS].acc : '0;

endmodule
